// ----- hdl/vdmc_pkg.sv -----
// ----------------------------------------------------------------------------
// vdmc_pkg
// Shared types and constants for the drive mode controller.
// ----------------------------------------------------------------------------
package vdmc_pkg;

    localparam int ADC_BITS_DEF = 12;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam int QUO_W      = 16;
    localparam int DIV_STEPS  = 16;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam int OUT_FIELDS_W = 35;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [15:0]        Q15_ONE  = 16'h8000;
    localparam logic signed [15:0] FULL_FWD = 16'sd25600;
    localparam logic signed [15:0] FULL_REV = -16'sd25600;

    localparam logic [CFG_ADDR_W-1:0] REG_ADC_LOW    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ADC_HIGH   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_THR    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_CRUISE_THR = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_CRUISE_VEL = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SPEED_TH   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_SOC_TH     = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_MOTOR_TYPE = 3'd7;

    localparam logic [1:0] MOTOR_MIN_THR = 2'd0;
    localparam logic [1:0] MOTOR_HOLD    = 2'd1;

    typedef enum logic [1:0] {
        MODE_PARK    = 2'd0,
        MODE_DRIVE   = 2'd1,
        MODE_REVERSE = 2'd2,
        MODE_CRUISE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_DIV  = 2'd1,
        ST_FIN  = 2'd2
    } t_ctrl_state;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
    } t_dp_sts;

endpackage

// ----- hdl/vehicle_drive_mode_controller_top.sv -----
// ----------------------------------------------------------------------------
// vehicle_drive_mode_controller_top
// Drive mode controller: pedal normalization, park/drive/reverse/cruise
// state and throttle/velocity command generation.
// ----------------------------------------------------------------------------
// One control tick is taken at a time. A tick is captured in ST_IDLE, then
// passes through ST_DIV, where the restoring divider scales the pedal sample
// to Q1.15 (one quotient bit per cycle), and ST_FIN, which selects the
// command and advances the mode. The result sits in an output register, so
// the next tick is accepted while it waits; the commit of that next tick holds
// until the register is drained. There is no clearing pass after reset.
module vehicle_drive_mode_controller_top
    import vdmc_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // pedal_adc, brake_pressed, regen_on, switch_pin_a, switch_pin_b,
    // cruise_request, vehicle_speed, battery_charge, battery_cool, zero pad
    input  logic [((ADC_BITS+30+7)/8)*8-1:0] s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // throttle_cmd, velocity_cmd, mode_now, pedal_fault, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int OFS_BRAKE  = ADC_BITS;
    localparam int OFS_REGEN  = ADC_BITS + 1;
    localparam int OFS_PIN_A  = ADC_BITS + 2;
    localparam int OFS_PIN_B  = ADC_BITS + 3;
    localparam int OFS_CRUISE = ADC_BITS + 4;
    localparam int OFS_SPEED  = ADC_BITS + 5;
    localparam int OFS_CHARGE = ADC_BITS + 21;
    localparam int OFS_COOL   = ADC_BITS + 29;

    t_dp_cmd            dp_cmd;
    t_dp_sts            dp_sts;
    logic [15:0]        throttle_cmd;
    logic signed [15:0] velocity_cmd;
    logic [1:0]         mode_now;
    logic               pedal_fault;

    vdmc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (dp_cmd),
        .i_sts       (dp_sts)
    );

    vdmc_datapath #(
        .ADC_BITS (ADC_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (dp_cmd),
        .o_sts            (dp_sts),
        .i_pedal_adc      (s_axis_tdata[ADC_BITS-1:0]),
        .i_brake_pressed  (s_axis_tdata[OFS_BRAKE]),
        .i_regen_on       (s_axis_tdata[OFS_REGEN]),
        .i_switch_pin_a   (s_axis_tdata[OFS_PIN_A]),
        .i_switch_pin_b   (s_axis_tdata[OFS_PIN_B]),
        .i_cruise_request (s_axis_tdata[OFS_CRUISE]),
        .i_vehicle_speed  ($signed(s_axis_tdata[OFS_SPEED +: 16])),
        .i_battery_charge (s_axis_tdata[OFS_CHARGE +: 8]),
        .i_battery_cool   (s_axis_tdata[OFS_COOL]),
        .o_throttle_cmd   (throttle_cmd),
        .o_velocity_cmd   (velocity_cmd),
        .o_mode_now       (mode_now),
        .o_pedal_fault    (pedal_fault)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}},
                           pedal_fault, mode_now, velocity_cmd, throttle_cmd};

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a tick is in progress");

    a_commit_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.commit |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result committed over an undelivered transaction");

    a_throttle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> throttle_cmd <= Q15_ONE)
        else $error("throttle command above 1.0");
`endif

endmodule

// ----- hdl/vdmc_ctrl.sv -----
// ----------------------------------------------------------------------------
// vdmc_ctrl
// Sequencer: accept a tick, run the pedal divider, commit the result.
// ----------------------------------------------------------------------------
module vdmc_ctrl
    import vdmc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    t_ctrl_state r_state, n_state;
    logic        r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- hdl/vdmc_datapath.sv -----
// ----------------------------------------------------------------------------
// vdmc_datapath
// Config registers, pedal range check and serial divider, mode register
// and command selection.
// ----------------------------------------------------------------------------
module vdmc_datapath
    import vdmc_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic [ADC_BITS-1:0]   i_pedal_adc,
    input  logic                  i_brake_pressed,
    input  logic                  i_regen_on,
    input  logic                  i_switch_pin_a,
    input  logic                  i_switch_pin_b,
    input  logic                  i_cruise_request,
    input  logic signed [15:0]    i_vehicle_speed,
    input  logic [7:0]            i_battery_charge,
    input  logic                  i_battery_cool,
    output logic [15:0]           o_throttle_cmd,
    output logic signed [15:0]    o_velocity_cmd,
    output logic [1:0]            o_mode_now,
    output logic                  o_pedal_fault
);

    localparam logic [ADC_BITS-1:0] ADC_HIGH_RST = ADC_BITS'(12'hFFF);

    logic [ADC_BITS-1:0] r_adc_low, r_adc_high;
    logic [15:0]         r_min_thr, r_cruise_thr;
    logic signed [15:0]  r_cruise_vel, r_speed_th;
    logic [7:0]          r_soc_th;
    logic [1:0]          r_motor_type;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adc_low    <= '0;
            r_adc_high   <= ADC_HIGH_RST;
            r_min_thr    <= '0;
            r_cruise_thr <= '0;
            r_cruise_vel <= '0;
            r_speed_th   <= 16'sd256;
            r_soc_th     <= '0;
            r_motor_type <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_ADC_LOW:    r_adc_low    <= i_cfg_data[ADC_BITS-1:0];
                REG_ADC_HIGH:   r_adc_high   <= i_cfg_data[ADC_BITS-1:0];
                REG_MIN_THR:    r_min_thr    <= i_cfg_data[15:0];
                REG_CRUISE_THR: r_cruise_thr <= i_cfg_data[15:0];
                REG_CRUISE_VEL: r_cruise_vel <= $signed(i_cfg_data[15:0]);
                REG_SPEED_TH:   r_speed_th   <= $signed(i_cfg_data[15:0]);
                REG_SOC_TH:     r_soc_th     <= i_cfg_data[7:0];
                REG_MOTOR_TYPE: r_motor_type <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // captured tick
    logic                 r_brake, r_regen, r_pin_a, r_pin_b, r_cruise, r_cool;
    logic signed [15:0]   r_speed;
    logic [7:0]           r_charge;
    logic                 r_fault, r_span_zero;

    // divider
    logic [ADC_BITS-1:0]  r_span, r_rem;
    logic [QUO_W-1:0]     r_shift, r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;

    logic [ADC_BITS-1:0]  diff, span;
    logic                 in_range;
    logic [ADC_BITS:0]    trial;
    logic                 ge;

    assign in_range = (i_pedal_adc <= r_adc_high) && (i_pedal_adc >= r_adc_low);
    assign diff     = i_pedal_adc - r_adc_low;
    assign span     = r_adc_high - r_adc_low;
    assign trial    = {r_rem, r_shift[QUO_W-1]};
    assign ge       = trial >= {1'b0, r_span};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_brake     <= i_brake_pressed;
            r_regen     <= i_regen_on;
            r_pin_a     <= i_switch_pin_a;
            r_pin_b     <= i_switch_pin_b;
            r_cruise    <= i_cruise_request;
            r_speed     <= i_vehicle_speed;
            r_charge    <= i_battery_charge;
            r_cool      <= i_battery_cool;
            r_fault     <= !in_range;
            r_span_zero <= (span == '0);
            r_span      <= span;
            r_rem       <= diff >> 1;
            r_shift     <= {diff[0], {(QUO_W-1){1'b0}}};
            r_quo       <= '0;
            r_cnt       <= '0;
        end else if (i_cmd.step) begin
            r_rem   <= ge ? ADC_BITS'(trial - {1'b0, r_span}) : trial[ADC_BITS-1:0];
            r_quo   <= {r_quo[QUO_W-2:0], ge};
            r_shift <= {r_shift[QUO_W-2:0], 1'b0};
            r_cnt   <= r_cnt + 1'b1;
        end
    end

    assign o_sts.div_last = (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));

    // command selection
    t_mode              r_mode, n_mode;
    logic [15:0]        thr, pmin, cmd_t;
    logic signed [15:0] full, cmd_v;
    logic               sw_rev, sw_drv, sw_park, slow;

    assign thr     = (r_fault || r_span_zero) ? 16'd0 : r_quo;
    assign pmin    = (r_min_thr > Q15_ONE) ? Q15_ONE : r_min_thr;
    assign sw_rev  = !r_pin_a && !r_pin_b;
    assign sw_drv  = r_pin_a && r_pin_b;
    assign sw_park = !sw_rev && !sw_drv;
    assign slow    = r_speed < r_speed_th;
    assign full    = (r_mode == MODE_DRIVE) ? FULL_FWD : FULL_REV;

    always_comb begin
        cmd_t  = '0;
        cmd_v  = '0;
        n_mode = r_mode;
        unique case (r_mode) inside
            MODE_DRIVE, MODE_REVERSE: begin
                if (r_brake) begin
                    cmd_t = '0;
                end else if (r_mode == MODE_DRIVE && r_regen && r_charge < r_soc_th
                             && r_cool) begin
                    cmd_t = thr;
                    cmd_v = (thr == '0) ? 16'sd0 : full;
                end else if (r_motor_type == MOTOR_MIN_THR) begin
                    if (thr != '0) begin
                        cmd_t = (thr < pmin) ? pmin : thr;
                        cmd_v = full;
                    end
                end else if (r_motor_type == MOTOR_HOLD) begin
                    cmd_t = thr;
                    cmd_v = full;
                end
                if (r_mode == MODE_DRIVE) begin
                    if (sw_rev && slow) n_mode = MODE_REVERSE;
                    else if (sw_park && slow) n_mode = MODE_PARK;
                    else if (r_cruise) n_mode = MODE_CRUISE;
                end else begin
                    if (sw_drv && r_brake && slow) n_mode = MODE_DRIVE;
                    else if (sw_park && r_brake && slow) n_mode = MODE_PARK;
                end
            end
            MODE_CRUISE: begin
                cmd_t = (r_cruise_thr > Q15_ONE) ? Q15_ONE : r_cruise_thr;
                cmd_v = r_cruise_vel;
                if (r_brake || !r_cruise) n_mode = MODE_DRIVE;
            end
            default: begin
                cmd_t = Q15_ONE;
                cmd_v = '0;
                if (sw_drv && r_brake && slow) n_mode = MODE_DRIVE;
                else if (sw_rev && r_brake && slow) n_mode = MODE_REVERSE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PARK;
        end else if (i_cmd.commit) begin
            r_mode <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_throttle_cmd <= cmd_t;
            o_velocity_cmd <= cmd_v;
            o_mode_now     <= n_mode;
            o_pedal_fault  <= r_fault;
        end
    end

endmodule

// ----- sim/drive_cmd_checker.sv -----
// ----------------------------------------------------------------------------
// drive_cmd_checker
// Watches the register port and both streams of the drive mode controller.
// Keeps its own copy of the registers and the drive mode, predicts the
// throttle/velocity command, mode and pedal fault for every accepted control
// tick and compares each accepted command against the oldest prediction.
// ----------------------------------------------------------------------------
module drive_cmd_checker
    import vdmc_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF,
    parameter int IN_W     = ((ADC_BITS + 30 + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_tick_valid,
    input  logic                  i_tick_ready,
    input  logic [IN_W-1:0]       i_tick_data,
    input  logic                  i_cmd_valid,
    input  logic                  i_cmd_ready,
    input  logic [OUT_TDATA_W-1:0] i_cmd_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct {
        logic [15:0]        throttle;
        logic signed [15:0] velocity;
        t_mode              mode;
        logic               fault;
    } t_drive_cmd;

    logic [ADC_BITS-1:0] adc_lo;
    logic [ADC_BITS-1:0] adc_hi;
    logic [15:0]         thr_min;
    logic [15:0]         thr_cruise;
    logic signed [15:0]  vel_cruise;
    logic signed [15:0]  speed_th;
    logic [7:0]          soc_th;
    logic [1:0]          motor;
    t_mode               mode;

    t_drive_cmd expected_cmds[$];
    int         fail_cnt = 0;

    assign o_fail_count = fail_cnt;

    function automatic logic [15:0] clamp_q15(input logic [15:0] v);
        return (v > Q15_ONE) ? Q15_ONE : v;
    endfunction

    // Compute the command for one tick and advance the drive mode.
    function automatic t_drive_cmd next_drive_cmd(input logic [IN_W-1:0] d);
        logic [ADC_BITS-1:0] pedal;
        logic                brake;
        logic                regen;
        logic                pin_a;
        logic                pin_b;
        logic                cruise;
        logic signed [15:0]  speed;
        logic [7:0]          charge;
        logic                cool;
        logic                slow;
        logic                sw_rev;
        logic                sw_drv;
        logic                sw_park;
        logic [15:0]         pmin;
        logic signed [15:0]  full;
        int                  thr;
        t_drive_cmd          c;

        pedal   = d[ADC_BITS-1:0];
        brake   = d[ADC_BITS];
        regen   = d[ADC_BITS+1];
        pin_a   = d[ADC_BITS+2];
        pin_b   = d[ADC_BITS+3];
        cruise  = d[ADC_BITS+4];
        speed   = d[ADC_BITS+20 -: 16];
        charge  = d[ADC_BITS+28 -: 8];
        cool    = d[ADC_BITS+29];
        sw_rev  = !pin_a && !pin_b;
        sw_drv  = pin_a && pin_b;
        sw_park = !sw_rev && !sw_drv;
        slow    = speed < speed_th;
        pmin    = clamp_q15(thr_min);
        thr     = 0;

        if (pedal > adc_hi || pedal < adc_lo) begin
            c.fault = 1'b1;
        end else begin
            c.fault = 1'b0;
            if (adc_hi != adc_lo)
                thr = ((int'(pedal) - int'(adc_lo)) << 15) / (int'(adc_hi) - int'(adc_lo));
        end

        c.throttle = '0;
        c.velocity = '0;
        case (mode)
            MODE_DRIVE, MODE_REVERSE: begin
                full = (mode == MODE_DRIVE) ? FULL_FWD : FULL_REV;
                if (!brake) begin
                    if (mode == MODE_DRIVE && regen && charge < soc_th && cool) begin
                        c.throttle = thr[15:0];
                        c.velocity = (thr == 0) ? 16'sd0 : full;
                    end else if (motor == MOTOR_MIN_THR) begin
                        if (thr != 0) begin
                            c.throttle = (thr < int'(pmin)) ? pmin : thr[15:0];
                            c.velocity = full;
                        end
                    end else if (motor == MOTOR_HOLD) begin
                        c.throttle = thr[15:0];
                        c.velocity = full;
                    end
                end
                if (mode == MODE_DRIVE) begin
                    if (sw_rev && slow)       mode = MODE_REVERSE;
                    else if (sw_park && slow) mode = MODE_PARK;
                    else if (cruise)          mode = MODE_CRUISE;
                end else begin
                    if (sw_drv && brake && slow)       mode = MODE_DRIVE;
                    else if (sw_park && brake && slow) mode = MODE_PARK;
                end
            end
            MODE_CRUISE: begin
                c.throttle = clamp_q15(thr_cruise);
                c.velocity = vel_cruise;
                if (brake || !cruise) mode = MODE_DRIVE;
            end
            default: begin
                c.throttle = Q15_ONE;
                if (sw_drv && brake && slow)      mode = MODE_DRIVE;
                else if (sw_rev && brake && slow) mode = MODE_REVERSE;
            end
        endcase
        c.mode = mode;
        return c;
    endfunction

    always @(posedge i_clk) begin
        t_drive_cmd exp_c;
        t_drive_cmd got;

        if (!i_rst_n) begin
            adc_lo     = '0;
            adc_hi     = ADC_BITS'(12'hFFF);
            thr_min    = '0;
            thr_cruise = '0;
            vel_cruise = '0;
            speed_th   = 16'sd256;
            soc_th     = '0;
            motor      = MOTOR_MIN_THR;
            mode       = MODE_PARK;
            expected_cmds.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_ADC_LOW:    adc_lo     = i_cfg_data[ADC_BITS-1:0];
                    REG_ADC_HIGH:   adc_hi     = i_cfg_data[ADC_BITS-1:0];
                    REG_MIN_THR:    thr_min    = i_cfg_data;
                    REG_CRUISE_THR: thr_cruise = i_cfg_data;
                    REG_CRUISE_VEL: vel_cruise = i_cfg_data;
                    REG_SPEED_TH:   speed_th   = i_cfg_data;
                    REG_SOC_TH:     soc_th     = i_cfg_data[7:0];
                    REG_MOTOR_TYPE: motor      = i_cfg_data[1:0];
                    default: ;
                endcase
            end

            if (i_tick_valid && i_tick_ready)
                expected_cmds.push_back(next_drive_cmd(i_tick_data));

            if (i_cmd_valid && i_cmd_ready) begin
                got.throttle = i_cmd_data[15:0];
                got.velocity = i_cmd_data[31:16];
                got.mode     = t_mode'(i_cmd_data[33:32]);
                got.fault    = i_cmd_data[34];
                if (expected_cmds.size() == 0) begin
                    $error("command transaction with no tick pending: throttle_cmd %0d",
                           got.throttle);
                    fail_cnt++;
                end else begin
                    exp_c = expected_cmds.pop_front();
                    if (got.throttle !== exp_c.throttle) begin
                        $error("throttle_cmd mismatch: expected %0d, actual %0d",
                               exp_c.throttle, got.throttle);
                        fail_cnt++;
                    end
                    if (got.velocity !== exp_c.velocity) begin
                        $error("velocity_cmd mismatch: expected %0d, actual %0d",
                               exp_c.velocity, got.velocity);
                        fail_cnt++;
                    end
                    if (got.mode !== exp_c.mode) begin
                        $error("mode_now mismatch: expected %0d, actual %0d",
                               exp_c.mode, got.mode);
                        fail_cnt++;
                    end
                    if (got.fault !== exp_c.fault) begin
                        $error("pedal_fault mismatch: expected %0d, actual %0d",
                               exp_c.fault, got.fault);
                        fail_cnt++;
                    end
                end
            end
        end
        o_pending = expected_cmds.size();
    end

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stimulus for the drive mode controller: a directed walk through every
// drive mode, pedal limit case and motor type, then random control ticks
// under several register settings with random stalls on both streams and
// one long output hold-off. Checking is done by drive_cmd_checker.
// ----------------------------------------------------------------------------
module tb;
    import vdmc_pkg::*;

    localparam int ADC_BITS   = ADC_BITS_DEF;
    localparam int IN_W       = ((ADC_BITS + 30 + 7) / 8) * 8;
    localparam int RUN_LIMIT  = 400000;
    localparam int SEG_TICKS  = 334;
    localparam int HOLD_CYCLES = 400;

    localparam logic [1:0] MOTOR_NONE   = 2'd2;
    localparam logic [1:0] MOTOR_UNUSED = 2'd3;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_W-1:0]        s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int fail_count;
    int pending;
    int cycle_cnt = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;

    logic [ADC_BITS-1:0] adc_lo_cur;
    logic [ADC_BITS-1:0] adc_hi_cur;
    logic signed [15:0]  speed_th_cur;

    always #5 i_clk = ~i_clk;

    vehicle_drive_mode_controller_top #(
        .ADC_BITS (ADC_BITS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    drive_cmd_checker #(
        .ADC_BITS (ADC_BITS),
        .IN_W     (IN_W)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_tick_valid (s_axis_tvalid),
        .i_tick_ready (s_axis_tready),
        .i_tick_data  (s_axis_tdata),
        .i_cmd_valid  (m_axis_tvalid),
        .i_cmd_ready  (m_axis_tready),
        .i_cmd_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= RUN_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Output side: random backpressure, plus a counted hold-off on request.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function automatic logic [IN_W-1:0] tick(
        input logic [ADC_BITS-1:0] pedal,
        input logic brake, input logic regen, input logic pin_a, input logic pin_b,
        input logic cruise, input logic signed [15:0] speed,
        input logic [7:0] charge, input logic cool
    );
        logic [IN_W-1:0] d;
        d = '0;
        d[ADC_BITS-1:0]    = pedal;
        d[ADC_BITS]        = brake;
        d[ADC_BITS+1]      = regen;
        d[ADC_BITS+2]      = pin_a;
        d[ADC_BITS+3]      = pin_b;
        d[ADC_BITS+4]      = cruise;
        d[ADC_BITS+20 -: 16] = speed;
        d[ADC_BITS+28 -: 8]  = charge;
        d[ADC_BITS+29]     = cool;
        return d;
    endfunction

    function automatic logic [IN_W-1:0] rand_tick();
        logic [ADC_BITS-1:0] pedal;
        logic signed [15:0]  speed;
        int                  s;
        if (adc_lo_cur <= adc_hi_cur && $urandom_range(99) < 70)
            pedal = ADC_BITS'($urandom_range(adc_hi_cur, adc_lo_cur));
        else
            pedal = ADC_BITS'($urandom_range((1 << ADC_BITS) - 1));
        if ($urandom_range(99) < 60) begin
            s = int'(speed_th_cur) + int'($urandom_range(600)) - 300;
            if (s > 32767)  s = 32767;
            if (s < -32768) s = -32768;
            speed = s[15:0];
        end else begin
            speed = 16'($urandom_range(65535));
        end
        return tick(pedal, $urandom_range(99) < 30, 1'($urandom_range(1)),
                    1'($urandom_range(1)), 1'($urandom_range(1)),
                    $urandom_range(99) < 60, speed,
                    8'($urandom_range(255)), 1'($urandom_range(1)));
    endfunction

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [15:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_config(
        input logic [ADC_BITS-1:0] lo, input logic [ADC_BITS-1:0] hi,
        input logic [15:0] thr_min, input logic [15:0] thr_cruise,
        input logic signed [15:0] vel_cruise, input logic signed [15:0] speed_th,
        input logic [7:0] soc_th, input logic [1:0] motor
    );
        write_reg(REG_ADC_LOW,    16'(lo));
        write_reg(REG_ADC_HIGH,   16'(hi));
        write_reg(REG_MIN_THR,    thr_min);
        write_reg(REG_CRUISE_THR, thr_cruise);
        write_reg(REG_CRUISE_VEL, vel_cruise);
        write_reg(REG_SPEED_TH,   speed_th);
        write_reg(REG_SOC_TH,     16'(soc_th));
        write_reg(REG_MOTOR_TYPE, 16'(motor));
        adc_lo_cur   = lo;
        adc_hi_cur   = hi;
        speed_th_cur = speed_th;
    endtask

    task automatic rand_config();
        logic [ADC_BITS-1:0] lo;
        logic [ADC_BITS-1:0] hi;
        logic [15:0]         mn;
        logic [15:0]         ct;
        logic signed [15:0]  cv;
        logic signed [15:0]  st;
        logic [7:0]          soc;
        int                  r;
        r = $urandom_range(99);
        if (r < 15) begin
            hi = ADC_BITS'($urandom_range(4095, 1));
            lo = hi;
        end else if (r < 25) begin
            hi = ADC_BITS'($urandom_range(4094, 1));
            lo = ADC_BITS'($urandom_range(4095, hi + 1));
        end else if (r < 40) begin
            lo = 0;
            hi = 4095;
        end else begin
            lo = ADC_BITS'($urandom_range(2000));
            hi = ADC_BITS'($urandom_range(4095, lo + 1));
        end
        case ($urandom_range(9))
            0:       mn = 16'd0;
            1:       mn = Q15_ONE;
            2:       mn = 16'($urandom_range(65535, 32769));
            default: mn = 16'($urandom_range(32768));
        endcase
        case ($urandom_range(5))
            0:       ct = 16'd0;
            1:       ct = Q15_ONE;
            2:       ct = 16'($urandom_range(65535, 32769));
            default: ct = 16'($urandom_range(32768));
        endcase
        case ($urandom_range(4))
            0:       cv = -16'sd32768;
            1:       cv = 16'sd32767;
            default: cv = 16'($urandom_range(65535));
        endcase
        case ($urandom_range(9))
            0:       st = -16'sd32768;
            1:       st = 16'sd32767;
            default: st = 16'($urandom_range(1792)) - 16'sd256;
        endcase
        case ($urandom_range(4))
            0:       soc = 8'd0;
            1:       soc = 8'd255;
            default: soc = 8'($urandom_range(255));
        endcase
        set_config(lo, hi, mn, ct, cv, st, soc, 2'($urandom_range(3)));
    endtask

    task automatic send_tick(input logic [IN_W-1:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle_pct = 34;
        recv_idle_pct = 50;

        set_config(12'd100, 12'd3000, 16'd10169, 16'hFFFF, -16'sd32768, 16'sd256,
                   8'd200, MOTOR_MIN_THR);
        send_tick(tick(12'd0,    0, 0, 1, 1, 0, 16'sd0,      8'd255, 0));
        send_tick(tick(12'd4095, 1, 1, 1, 1, 1, 16'sd255,    8'd0,   1));
        send_tick(tick(12'd100,  0, 0, 1, 1, 0, 16'sd256,    8'd128, 0));
        send_tick(tick(12'd1000, 0, 0, 1, 1, 0, 16'sd0,      8'd255, 1));
        send_tick(tick(12'd200,  0, 0, 1, 1, 0, 16'sd0,      8'd255, 1));
        send_tick(tick(12'd3000, 0, 1, 1, 1, 0, 16'sd0,      8'd0,   1));
        send_tick(tick(12'd1500, 1, 0, 0, 0, 0, -16'sd32768, 8'd10,  1));
        send_tick(tick(12'd3000, 0, 0, 0, 0, 0, 16'sd32767,  8'd10,  0));
        send_tick(tick(12'd2000, 1, 0, 1, 0, 0, -16'sd1,     8'd10,  0));
        send_tick(tick(12'd50,   1, 0, 0, 0, 0, 16'sd0,      8'd10,  0));
        send_tick(tick(12'd2000, 1, 0, 1, 1, 0, 16'sd32767,  8'd10,  0));
        send_tick(tick(12'd2000, 1, 0, 1, 1, 0, 16'sd100,    8'd10,  0));
        send_tick(tick(12'd2000, 0, 0, 1, 1, 1, 16'sd32767,  8'd10,  0));
        send_tick(tick(12'd2000, 0, 0, 1, 1, 1, 16'sd32767,  8'd10,  0));
        send_tick(tick(12'd2000, 0, 0, 1, 1, 0, 16'sd32767,  8'd10,  0));
        send_tick(tick(12'd2000, 0, 0, 1, 0, 0, 16'sd255,    8'd10,  0));
        drain();

        set_config(12'd2048, 12'd2048, 16'd40000, Q15_ONE, 16'sd32767, 16'sd32767,
                   8'd255, MOTOR_HOLD);
        send_tick(tick(12'd2048, 1, 0, 1, 1, 0, 16'sd0,      8'd254, 1));
        send_tick(tick(12'd2048, 0, 1, 1, 1, 0, 16'sd0,      8'd254, 1));
        send_tick(tick(12'd2047, 0, 0, 1, 1, 0, 16'sd32767,  8'd254, 1));
        drain();

        set_config(12'd3000, 12'd100, 16'd0, 16'd0, 16'sd0, -16'sd32768,
                   8'd0, MOTOR_UNUSED);
        send_tick(tick(12'd1500, 0, 1, 1, 1, 1, 16'sd0,      8'd0,   1));
        send_tick(tick(12'd1500, 1, 0, 1, 1, 1, 16'sd0,      8'd0,   1));
        send_tick(tick(12'd4095, 0, 0, 0, 0, 0, -16'sd32768, 8'd0,   1));
        drain();

        set_config(12'd0, 12'd4095, Q15_ONE, 16'd0, -16'sd32768, 16'sd32767,
                   8'd255, MOTOR_NONE);
        send_tick(tick(12'd4095, 1, 0, 1, 1, 0, 16'sd0,      8'd0,   1));
        send_tick(tick(12'd4095, 0, 0, 1, 1, 0, 16'sd0,      8'd0,   0));
        drain();

        for (int seg = 0; seg < 6; seg++) begin
            case (seg / 2)
                0: begin
                    send_idle_pct = 34;
                    recv_idle_pct = 50;
                end
                1: begin
                    send_idle_pct = 50;
                    recv_idle_pct = 34;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            rand_config();
            if (seg == 4) hold_left = HOLD_CYCLES;
            repeat (SEG_TICKS) send_tick(rand_tick());
            drain();
        end

        repeat (40) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
